FILE: rtl/bone_global_transform_core_macros.svh
// assertion macros for the bone global transform core
// used by the top level only; expects clk_i and rst_ni in scope
`ifndef BONE_GLOBAL_TRANSFORM_CORE_MACROS_SVH
`define BONE_GLOBAL_TRANSFORM_CORE_MACROS_SVH

// property holds at every clock edge outside reset
`define BGT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition implies a consequence in the next cycle
`define BGT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: rtl/bgt_pkg.sv
// shared types, constants and fixed point helpers of the bone transform core
// no dependencies
package bgt_pkg;

  localparam int unsigned MaxBones = 256;
  localparam int unsigned SlotW    = $clog2(MaxBones);

  localparam logic [14:0] SinA = 15'd25736;
  localparam logic [13:0] SinB = 14'd10512;
  localparam logic [10:0] SinC = 11'd1160;

  typedef struct packed {
    logic signed [15:0] mat_a;
    logic signed [15:0] mat_b;
    logic signed [15:0] mat_c;
    logic signed [15:0] mat_d;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        skew_x;
    logic [15:0]        skew_y;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic [1:0]         mode;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // round half up by 2^14, saturate to 16 bits
  function automatic logic signed [15:0] rnd14_sat16(input logic signed [32:0] v);
    logic signed [33:0] t;
    logic signed [19:0] r;
    t = 34'(v) + 34'sd8192;
    r = 20'(t >>> 14);
    if (r > 20'sd32767) return 16'sh7fff;
    else if (r < -20'sd32768) return 16'sh8000;
    else return r[15:0];
  endfunction

  // round half up by 2^12, saturate to 16 bits
  function automatic logic signed [15:0] rnd12_sat16(input logic signed [31:0] v);
    logic signed [32:0] t;
    logic signed [20:0] r;
    t = 33'(v) + 33'sd2048;
    r = 21'(t >>> 12);
    if (r > 21'sd32767) return 16'sh7fff;
    else if (r < -21'sd32768) return 16'sh8000;
    else return r[15:0];
  endfunction

  // round half up by 2^12, saturate to 32 bits
  function automatic logic signed [31:0] rnd12_sat32(input logic signed [49:0] v);
    logic signed [50:0] t;
    logic signed [38:0] r;
    t = 51'(v) + 51'sd2048;
    r = 39'(t >>> 12);
    if (r > 39'sd2147483647) return 32'sh7fffffff;
    else if (r < -39'sd2147483648) return 32'sh80000000;
    else return r[31:0];
  endfunction

endpackage

FILE: rtl/bgt_if.sv
// valid/ready channel interfaces for bone words and matrix result words
// no dependencies
interface bgt_in_if;
  logic               valid;
  logic               ready;
  logic [7:0]         bone_index;
  logic [8:0]         parent_index;
  logic               fixed_rotation;
  logic [1:0]         scale_type;
  logic [1:0]         scale_mode;
  logic signed [31:0] local_x;
  logic signed [31:0] local_y;
  logic [15:0]        local_skew_x;
  logic [15:0]        local_skew_y;
  logic signed [15:0] local_scale_x;
  logic signed [15:0] local_scale_y;

  modport source (output valid, bone_index, parent_index, fixed_rotation, scale_type,
                  scale_mode, local_x, local_y, local_skew_x, local_skew_y,
                  local_scale_x, local_scale_y, input ready);
  modport sink (input valid, bone_index, parent_index, fixed_rotation, scale_type,
                scale_mode, local_x, local_y, local_skew_x, local_skew_y,
                local_scale_x, local_scale_y, output ready);
endinterface

interface bgt_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         out_bone;
  logic signed [15:0] mat_a;
  logic signed [15:0] mat_b;
  logic signed [15:0] mat_c;
  logic signed [15:0] mat_d;
  logic signed [31:0] world_x;
  logic signed [31:0] world_y;

  modport source (output valid, out_bone, mat_a, mat_b, mat_c, mat_d, world_x, world_y,
                  input ready);
  modport sink (input valid, out_bone, mat_a, mat_b, mat_c, mat_d, world_x, world_y,
                output ready);
endinterface

FILE: rtl/bone_global_transform_core.sv
// bone global transform core: one bone word in, one matrix/position word out.
// Input channel in_i carries a bone slot, its parent slot (256 = none) and the
// summed local position, skew and scale. The parent entry is read from a bone
// table ram, the position is mapped through the parent matrix, skew and scale
// are inherited, and four sines are formed by a five step polynomial pipeline.
// Accepted words pass the ram read, position, sine and matrix steps on the
// way to out_o. One bone is in flight at a time; a new word is taken once
// the previous one has left the matrix step. The sequence is set by the ram
// read plus the dependent multiplies of the sine polynomial.
// The result sits in an output register; while out_o is stalled the next word
// may still be accepted and run up to the matrix step, where it waits.
// A parent is read only after a completed bone wrote its slot, so no
// forwarding is needed. Reset clears the control state only; the bone table
// holds no valid bits and an unwritten parent slot reads undefined data.
// Reading a parent slot equal to the bone slot returns the old contents.
// Depends on bgt_pkg, bgt_if, bgt_ram and the macros header.
`include "bone_global_transform_core_macros.svh"

module bone_global_transform_core (
  input  logic clk_i,
  input  logic rst_ni,
  bgt_in_if.sink    in_i,
  bgt_out_if.source out_o
);
  import bgt_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StRead, StPos, StSin1, StSin2, StSin3, StSin4, StSin5, StMat
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  // captured word
  logic [7:0]         bone_q;
  logic [8:0]         par_q;
  logic               fixed_q;
  logic [1:0]         stype_q, smode_q;
  logic signed [31:0] lx_q, ly_q;
  logic [15:0]        lskx_q, lsky_q;
  logic signed [15:0] lscx_q, lscy_q;

  // parent dependent stage
  entry_t             rd_entry;
  logic               has_par;
  logic signed [47:0] pax_q, pcy_q, pdy_q, pbx_q;
  logic signed [31:0] ppx_q, ppy_q;
  logic signed [31:0] scpx_q, scpy_q;
  logic               use_par_q, inh_scale_q;
  logic [15:0]        skx_q, sky_q;
  logic signed [31:0] wx_q, wy_q;
  logic signed [15:0] scx_q, scy_q;

  // sine lanes: cos sky, sin sky, sin skx, cos skx
  logic [15:0]        ang   [4];
  logic [14:0]        x_q   [4];
  logic               neg_q [4];
  logic [14:0]        x2_q  [4];
  logic [13:0]        y1_q  [4];
  logic [14:0]        y2_q  [4];
  logic signed [15:0] sin_q [4];

  // output word
  logic [7:0]         ob_q;
  logic signed [15:0] ma_q, mb_q, mc_q, md_q;
  logic signed [31:0] owx_q, owy_q;

  logic   mat_fire;
  entry_t wr_entry;
  logic signed [15:0] ma_d, mb_d, mc_d, md_d;

  assign has_par  = (par_q[8] == 1'b0);
  assign mat_fire = (state_q == StMat) && (!out_valid_q || out_o.ready);
  assign in_i.ready = (state_q == StIdle);

  bgt_ram #(.Width(EntryW), .Depth(MaxBones)) u_table (
    .clk_i   (clk_i),
    .we_i    (mat_fire),
    .waddr_i (bone_q[SlotW-1:0]),
    .wdata_i (wr_entry),
    .raddr_i (par_q[SlotW-1:0]),
    .rdata_o (rd_entry)
  );

  always_comb begin
    ang[0] = sky_q + 16'd16384;
    ang[1] = sky_q;
    ang[2] = skx_q;
    ang[3] = skx_q + 16'd16384;
  end

  always_comb begin
    ma_d = rnd14_sat16(33'(scx_q * sin_q[0]));
    mb_d = rnd14_sat16(33'(scx_q * sin_q[1]));
    mc_d = rnd14_sat16(-33'(scy_q * sin_q[2]));
    md_d = rnd14_sat16(33'(scy_q * sin_q[3]));
    wr_entry.mat_a   = ma_d;
    wr_entry.mat_b   = mb_d;
    wr_entry.mat_c   = mc_d;
    wr_entry.mat_d   = md_d;
    wr_entry.pos_x   = wx_q;
    wr_entry.pos_y   = wy_q;
    wr_entry.skew_x  = skx_q;
    wr_entry.skew_y  = sky_q;
    wr_entry.scale_x = scx_q;
    wr_entry.scale_y = scy_q;
    wr_entry.mode    = smode_q;
  end

  // control and registered output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      if (mat_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: if (in_i.valid) state_q <= StRead;
        StRead: state_q <= StPos;
        StPos:  state_q <= StSin1;
        StSin1: state_q <= StSin2;
        StSin2: state_q <= StSin3;
        StSin3: state_q <= StSin4;
        StSin4: state_q <= StSin5;
        StSin5: state_q <= StMat;
        StMat: begin
          if (mat_fire) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      bone_q  <= in_i.bone_index;
      par_q   <= in_i.parent_index;
      fixed_q <= in_i.fixed_rotation;
      stype_q <= in_i.scale_type;
      smode_q <= in_i.scale_mode;
      lx_q    <= in_i.local_x;
      ly_q    <= in_i.local_y;
      lskx_q  <= in_i.local_skew_x;
      lsky_q  <= in_i.local_skew_y;
      lscx_q  <= in_i.local_scale_x;
      lscy_q  <= in_i.local_scale_y;
    end
    if (state_q == StPos) begin
      pax_q       <= 48'(rd_entry.mat_a * lx_q);
      pcy_q       <= 48'(rd_entry.mat_c * ly_q);
      pdy_q       <= 48'(rd_entry.mat_d * ly_q);
      pbx_q       <= 48'(rd_entry.mat_b * lx_q);
      ppx_q       <= rd_entry.pos_x;
      ppy_q       <= rd_entry.pos_y;
      scpx_q      <= 32'(lscx_q * rd_entry.scale_x);
      scpy_q      <= 32'(lscy_q * rd_entry.scale_y);
      use_par_q   <= has_par;
      inh_scale_q <= has_par && (rd_entry.mode >= stype_q);
      if (has_par && !fixed_q) begin
        skx_q <= lskx_q + rd_entry.skew_x;
        sky_q <= lsky_q + rd_entry.skew_y;
      end else begin
        skx_q <= lskx_q;
        sky_q <= lsky_q;
      end
    end
    if (state_q == StSin1) begin
      if (use_par_q) begin
        wx_q <= rnd12_sat32(50'(pax_q) + 50'(pcy_q) + (50'(ppx_q) <<< 12));
        wy_q <= rnd12_sat32(50'(pdy_q) + 50'(pbx_q) + (50'(ppy_q) <<< 12));
      end else begin
        wx_q <= lx_q;
        wy_q <= ly_q;
      end
      scx_q <= inh_scale_q ? rnd12_sat16(scpx_q) : lscx_q;
      scy_q <= inh_scale_q ? rnd12_sat16(scpy_q) : lscy_q;
    end
    for (int i = 0; i < 4; i++) begin
      if (state_q == StSin1) begin
        // mirror odd quadrants onto the rising quarter wave
        x_q[i]   <= ang[i][14] ? (15'd16384 - {1'b0, ang[i][13:0]})
                               : {1'b0, ang[i][13:0]};
        neg_q[i] <= ang[i][15];
      end
      if (state_q == StSin2) x2_q[i] <= 15'((30'(x_q[i]) * 30'(x_q[i])) >> 14);
      if (state_q == StSin3) y1_q[i] <= SinB - 14'((26'(x2_q[i]) * 26'(SinC)) >> 14);
      if (state_q == StSin4) y2_q[i] <= SinA - 15'((29'(x2_q[i]) * 29'(y1_q[i])) >> 14);
      if (state_q == StSin5) begin
        sin_q[i] <= neg_q[i] ? -$signed(16'((30'(x_q[i]) * 30'(y2_q[i])) >> 14))
                             :  $signed(16'((30'(x_q[i]) * 30'(y2_q[i])) >> 14));
      end
    end
    if (mat_fire) begin
      ob_q  <= bone_q;
      ma_q  <= ma_d;
      mb_q  <= mb_d;
      mc_q  <= mc_d;
      md_q  <= md_d;
      owx_q <= wx_q;
      owy_q <= wy_q;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_bone = ob_q;
  assign out_o.mat_a    = ma_q;
  assign out_o.mat_b    = mb_q;
  assign out_o.mat_c    = mc_q;
  assign out_o.mat_d    = md_q;
  assign out_o.world_x  = owx_q;
  assign out_o.world_y  = owy_q;

  `BGT_ASSERT_NEXT(a_accept_reads, in_i.valid && in_i.ready, state_q == StRead, "no read")
  `BGT_ASSERT_NEXT(a_fire_shows, mat_fire, out_valid_q && state_q == StIdle, "word not shown")
  `BGT_ASSERT(a_no_overwrite, !(out_valid_q && !out_o.ready) || !mat_fire, "word overwritten")
endmodule

FILE: rtl/bgt_ram.sv
// generic single write port ram with registered read
// no dependencies
module bgt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
